/* sv/fcull_pkg.sv */
// Shared types and constants of the frustum cull test block.
package fcull_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int PLANE_COUNT     = 6;
   localparam int AXIS_COUNT      = 3;
   localparam int COEF_WIDTH      = 16;
   localparam int D_SHIFT         = 14;
   localparam int PLANE_WIDTH     = 4 * COEF_WIDTH;

   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_INDEX_LSB   = 3;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_ADDR_WIDTH  = CSR_INDEX_LSB + CSR_INDEX_WIDTH;

   typedef enum logic {
      MODE_BOX   = 1'b0,
      MODE_POINT = 1'b1
   } mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      PLANE_LEFT   = 3'd0,
      PLANE_RIGHT  = 3'd1,
      PLANE_BOTTOM = 3'd2,
      PLANE_TOP    = 3'd3,
      PLANE_FAR    = 3'd4,
      PLANE_NEAR   = 3'd5
   } plane_idx_type;

   // Per-stage load strobes handed to each plane unit.
   typedef struct packed {
      logic mul;
      logic sel;
      logic sum;
   } stage_en_type;

endpackage

/* sv/frustum_cull_test.sv */
// Top level of the frustum cull test: plane registers, pipeline control, result register.
//
// Tests one axis-aligned box (mode 0) or one point (mode 1) against six
// frustum planes per transaction. Each plane register is 64 bits at byte
// address 8*i (left, right, bottom, top, far, near): a in bits 15..0, b in
// 31..16, c in 47..32 (signed Q1.14) and d in 63..48 (signed integer). A
// point is in front of a plane when a*x+b*y+c*z+d*2^14 is strictly positive.
// A box is kept unless for some plane none of its corners is in front; a
// point must be in front of all six planes. After reset every plane is zero,
// which rejects everything until software loads real planes. The block takes
// one transaction per clock while req_stall is low and passes each result
// through four register stages: multiply, corner select, sum and sign test,
// and the output register. Every stage has its own valid bit, so bubbles
// close up under a stalled output and new requests keep entering until all
// four stages are full. Write planes only while the block is idle.
module frustum_cull_test
   import fcull_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic signed [COORD_WIDTH-1:0] req_lo_x,
   input  logic signed [COORD_WIDTH-1:0] req_lo_y,
   input  logic signed [COORD_WIDTH-1:0] req_lo_z,
   input  logic signed [COORD_WIDTH-1:0] req_hi_x,
   input  logic signed [COORD_WIDTH-1:0] req_hi_y,
   input  logic signed [COORD_WIDTH-1:0] req_hi_z,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_inside_res,

   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]     paddr,
   input  logic [CSR_DATA_WIDTH-1:0]     pwdata,
   output logic [CSR_DATA_WIDTH-1:0]     prdata,
   output logic                          pready
);

   // ---------------------------------------------------------------
   // Plane registers
   // ---------------------------------------------------------------
   logic [PLANE_WIDTH-1:0]     plane_ff [PLANE_COUNT];
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic                       csr_hit;
   logic                       csr_write;

   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_WIDTH-1:CSR_INDEX_LSB];
   // Indexes past the near plane are unmapped: drop writes, read zero.
   assign csr_hit   = (csr_index <= PLANE_NEAR);
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = csr_hit ? plane_ff[csr_index] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PLANE_COUNT; i++) begin
            plane_ff[i] <= '0;
         end
      end else if (csr_write && csr_hit) begin
         plane_ff[csr_index] <= pwdata;
      end
   end

   // ---------------------------------------------------------------
   // Pipeline control: a stage loads when it is empty or the next one loads
   // ---------------------------------------------------------------
   logic         mul_valid_ff, sel_valid_ff, sum_valid_ff, out_valid_ff;
   logic         mul_rdy, sel_rdy, sum_rdy, out_rdy;
   stage_en_type stage_en;
   mode_type     mode_s1_ff;
   logic         inside_ff;
   logic         inside_in;
   logic [PLANE_COUNT-1:0] front;

   assign out_rdy = !out_valid_ff || !rsp_stall;
   assign sum_rdy = !sum_valid_ff || out_rdy;
   assign sel_rdy = !sel_valid_ff || sum_rdy;
   assign mul_rdy = !mul_valid_ff || sel_rdy;

   // Hold the request when every stage is full and the output is stalled.
   assign req_stall = !mul_rdy;

   assign stage_en.mul = mul_rdy;
   assign stage_en.sel = sel_rdy;
   assign stage_en.sum = sum_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sel_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (mul_rdy) mul_valid_ff <= req_valid;
         if (sel_rdy) sel_valid_ff <= mul_valid_ff;
         if (sum_rdy) sum_valid_ff <= sel_valid_ff;
         if (out_rdy) out_valid_ff <= sum_valid_ff;
      end
   end

   // Mode only matters at corner select, one stage in.
   always_ff @(posedge clock) begin
      if (mul_rdy) begin
         mode_s1_ff <= mode_type'(req_mode);
      end
   end

   // ---------------------------------------------------------------
   // Plane units
   // ---------------------------------------------------------------
   logic signed [COORD_WIDTH-1:0] lo_vec [AXIS_COUNT];
   logic signed [COORD_WIDTH-1:0] hi_vec [AXIS_COUNT];

   assign lo_vec[0] = req_lo_x;
   assign lo_vec[1] = req_lo_y;
   assign lo_vec[2] = req_lo_z;
   assign hi_vec[0] = req_hi_x;
   assign hi_vec[1] = req_hi_y;
   assign hi_vec[2] = req_hi_z;

   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
      fcull_plane #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_plane (
         .clock   (clock),
         .en      (stage_en),
         .plane   (plane_ff[p]),
         .mode_s1 (mode_s1_ff),
         .lo      (lo_vec),
         .hi      (hi_vec),
         .front   (front[p])
      );
   end

   // ---------------------------------------------------------------
   // Output register: kept only when in front of every plane
   // ---------------------------------------------------------------
   assign inside_in = &front;

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         inside_ff <= inside_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_inside_res = inside_ff;

`ifndef NO_ASSERTIONS
   // The input may only stall when the whole pipeline is full and backed up.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (mul_valid_ff && sel_valid_ff && sum_valid_ff && out_valid_ff
                     && rsp_stall))
      else $error("request stalled with room in the pipeline");

   // A taken result with nothing behind it leaves the output empty.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_stall && !sum_valid_ff) |=> !out_valid_ff)
      else $error("result repeated after transaction");

   // A request taken into an empty pipeline reaches the output through every stage without a stall.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !mul_valid_ff && !sel_valid_ff && !sum_valid_ff
       && !out_valid_ff) |-> ##4 out_valid_ff)
      else $error("result missing after pipeline latency");

   // Nothing is presented right after reset.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

/* sv/fcull_plane.sv */
// Three-stage plane unit: multiply, pick best corner per axis, sum and sign test.
module fcull_plane
   import fcull_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  stage_en_type                  en,
   input  logic [PLANE_WIDTH-1:0]        plane,
   input  mode_type                      mode_s1,
   input  logic signed [COORD_WIDTH-1:0] lo [AXIS_COUNT],
   input  logic signed [COORD_WIDTH-1:0] hi [AXIS_COUNT],
   output logic                          front
);

   localparam int PROD_W = COEF_WIDTH + COORD_WIDTH;
   localparam int BASE_W = (PROD_W > COEF_WIDTH + D_SHIFT) ? PROD_W : COEF_WIDTH + D_SHIFT;
   localparam int SUM_W  = BASE_W + 2;

   logic signed [COEF_WIDTH-1:0] coef [AXIS_COUNT];
   logic signed [COEF_WIDTH-1:0] d_coef;

   logic signed [PROD_W-1:0] prod_lo_ff [AXIS_COUNT];
   logic signed [PROD_W-1:0] prod_lo_in [AXIS_COUNT];
   logic signed [PROD_W-1:0] prod_hi_ff [AXIS_COUNT];
   logic signed [PROD_W-1:0] prod_hi_in [AXIS_COUNT];
   logic signed [PROD_W-1:0] term_ff    [AXIS_COUNT];
   logic signed [PROD_W-1:0] term_in    [AXIS_COUNT];
   logic signed [SUM_W-1:0]  d_term;
   logic signed [SUM_W-1:0]  sum_in;
   logic                     front_ff;
   logic                     front_in;

   always_comb begin
      for (int k = 0; k < AXIS_COUNT; k++) begin
         coef[k] = plane[k*COEF_WIDTH +: COEF_WIDTH];
      end
      d_coef = plane[AXIS_COUNT*COEF_WIDTH +: COEF_WIDTH];
   end

   // Stage 1: one product per axis and bound.
   always_comb begin
      for (int k = 0; k < AXIS_COUNT; k++) begin
         prod_lo_in[k] = coef[k] * lo[k];
         prod_hi_in[k] = coef[k] * hi[k];
      end
   end

   // Stage 2: box mode keeps each axis term at its largest; point mode takes lo.
   always_comb begin
      for (int k = 0; k < AXIS_COUNT; k++) begin
         if (mode_s1 == MODE_POINT || prod_lo_ff[k] > prod_hi_ff[k]) begin
            term_in[k] = prod_lo_ff[k];
         end else begin
            term_in[k] = prod_hi_ff[k];
         end
      end
   end

   // Stage 3: strictly positive distance means in front.
   assign d_term   = SUM_W'(d_coef) <<< D_SHIFT;
   assign sum_in   = SUM_W'(term_ff[0]) + SUM_W'(term_ff[1]) + SUM_W'(term_ff[2]) + d_term;
   assign front_in = !sum_in[SUM_W-1] && (sum_in != '0);

   always_ff @(posedge clock) begin
      if (en.mul) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
      end
      if (en.sel) begin
         term_ff <= term_in;
      end
      if (en.sum) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the frustum cull test block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fcull_pkg::*;

   localparam int CW      = COORD_WIDTH_DEF;
   localparam int Q_ONE   = 1 << D_SHIFT;     // 1.0 in Q1.14
   localparam int CORNERS = 8;
   localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] COORD_MAX = ~COORD_MIN;

   // One box or point transaction, as seen on the request ports.
   typedef struct packed {
      mode_type               mode;
      logic signed [CW-1:0]   lo_x;
      logic signed [CW-1:0]   lo_y;
      logic signed [CW-1:0]   lo_z;
      logic signed [CW-1:0]   hi_x;
      logic signed [CW-1:0]   hi_y;
      logic signed [CW-1:0]   hi_z;
   } cull_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_mode  = 1'b0;
   logic signed [CW-1:0] req_lo_x  = '0;
   logic signed [CW-1:0] req_lo_y  = '0;
   logic signed [CW-1:0] req_lo_z  = '0;
   logic signed [CW-1:0] req_hi_x  = '0;
   logic signed [CW-1:0] req_hi_y  = '0;
   logic signed [CW-1:0] req_hi_z  = '0;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_inside_res;

   logic                      psel    = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   // Local copy of the plane registers, all zero after reset.
   logic [PLANE_WIDTH-1:0] plane_copy [PLANE_COUNT] = '{default: '0};

   // Predicted inside_res bits, oldest first.
   logic visibility_pending [$];
   int   mismatch_count = 0;

   // Idling controls for the sender and the stall process.
   bit sender_gaps       = 1'b0;
   bit receiver_gaps     = 1'b0;
   bit hold_off_request  = 1'b0;

   frustum_cull_test #(.COORD_WIDTH(CW)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_lo_x       (req_lo_x),
      .req_lo_y       (req_lo_y),
      .req_lo_z       (req_lo_z),
      .req_hi_x       (req_hi_x),
      .req_hi_y       (req_hi_y),
      .req_hi_z       (req_hi_z),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_inside_res (rsp_inside_res),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Strict sign test of a*x + b*y + c*z + d*2^14; zero counts as behind.
   function automatic logic in_front_of(input logic [PLANE_WIDTH-1:0] plane,
                                        input longint x, input longint y,
                                        input longint z);
      longint a, b, c, d, sum;
      a = longint'($signed(plane[15:0]));
      b = longint'($signed(plane[31:16]));
      c = longint'($signed(plane[47:32]));
      d = longint'($signed(plane[63:48]));
      sum = a * x + b * y + c * z + d * longint'(Q_ONE);
      return sum > 0;
   endfunction

   // Box mode: drop the box only if some plane has every corner behind it.
   // Point mode: keep the point only if it is in front of all six planes.
   function automatic logic predict_visibility(input cull_item_type item);
      longint lo [3];
      longint hi [3];
      longint cx, cy, cz;
      logic   visible, any_front;
      lo[0] = longint'($signed(item.lo_x));
      lo[1] = longint'($signed(item.lo_y));
      lo[2] = longint'($signed(item.lo_z));
      hi[0] = longint'($signed(item.hi_x));
      hi[1] = longint'($signed(item.hi_y));
      hi[2] = longint'($signed(item.hi_z));
      visible = 1'b1;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         if (item.mode == MODE_POINT) begin
            if (!in_front_of(plane_copy[p], lo[0], lo[1], lo[2]))
               visible = 1'b0;
         end else begin
            any_front = 1'b0;
            // Corners come from lo and hi as given, even when swapped.
            for (int k = 0; k < CORNERS; k++) begin
               cx = k[0] ? hi[0] : lo[0];
               cy = k[1] ? hi[1] : lo[1];
               cz = k[2] ? hi[2] : lo[2];
               if (in_front_of(plane_copy[p], cx, cy, cz))
                  any_front = 1'b1;
            end
            if (!any_front)
               visible = 1'b0;
         end
      end
      return visible;
   endfunction

   // ------------------------------------------------------------------
   // Checking: score every accepted result, predict every accepted request
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      cull_item_type seen;
      logic          want;
      if (!reset) begin
         // Score the result transaction against the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (visibility_pending.size() == 0) begin
               $display("%0t: result with nothing pending, expected none, actual %0b",
                        $time, rsp_inside_res);
               mismatch_count++;
            end else begin
               want = visibility_pending.pop_front();
               if (rsp_inside_res !== want) begin
                  $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                           $time, want, rsp_inside_res);
                  mismatch_count++;
               end
            end
         end
         // Predict from the request transaction exactly as the block took it.
         if (req_valid && !req_stall) begin
            seen.mode = mode_type'(req_mode);
            seen.lo_x = req_lo_x;
            seen.lo_y = req_lo_y;
            seen.lo_z = req_lo_z;
            seen.hi_x = req_hi_x;
            seen.hi_y = req_hi_y;
            seen.hi_z = req_hi_z;
            visibility_pending.push_back(predict_visibility(seen));
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stall bursts, plus one long hold-off on request
   // ------------------------------------------------------------------
   always begin
      @(posedge clock);
      if (hold_off_request) begin
         // Hold the output long enough for every stage to fill and the
         // input to back up behind it.
         rsp_stall <= 1'b1;
         repeat (60) @(posedge clock);
         hold_off_request = 1'b0;
         rsp_stall <= 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Shared drivers
   // ------------------------------------------------------------------

   // Offer one transaction and hold it until accepted; optionally drop
   // valid for a random burst afterward.
   task automatic send_item(input cull_item_type item);
      req_valid <= 1'b1;
      req_mode  <= item.mode;
      req_lo_x  <= item.lo_x;
      req_lo_y  <= item.lo_y;
      req_lo_z  <= item.lo_z;
      req_hi_x  <= item.hi_x;
      req_hi_y  <= item.hi_y;
      req_hi_z  <= item.hi_z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Stop offering, wait for every pending result, then let the pipeline
   // settle before the planes may change.
   task automatic wait_drained;
      req_valid <= 1'b0;
      @(posedge clock);
      while (visibility_pending.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Setup phase, then access phase on the register port, then back to idle.
   task automatic csr_access(input logic write_en, input int unsigned idx,
                             input logic [CSR_DATA_WIDTH-1:0] value,
                             output logic [CSR_DATA_WIDTH-1:0] read_back);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write_en;
      paddr   <= CSR_ADDR_WIDTH'(idx << CSR_INDEX_LSB);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      read_back = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(input int unsigned idx, input logic [PLANE_WIDTH-1:0] value);
      logic [CSR_DATA_WIDTH-1:0] unused;
      csr_access(1'b1, idx, value, unused);
      // Writes past the last plane are dropped by the block.
      if (idx < PLANE_COUNT)
         plane_copy[idx] = value;
   endtask

   task automatic check_plane_readback;
      logic [CSR_DATA_WIDTH-1:0] got;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         csr_access(1'b0, p, '0, got);
         if (got !== plane_copy[p]) begin
            $display("%0t: plane %0d readback mismatch, expected %h, actual %h",
                     $time, p, plane_copy[p], got);
            mismatch_count++;
         end
      end
   endtask

   function automatic logic [PLANE_WIDTH-1:0] plane_word(input int a, input int b,
                                                         input int c, input int d);
      return {16'(d), 16'(c), 16'(b), 16'(a)};
   endfunction

   // Axis-aligned cube |x|,|y|,|z| < half; faces themselves are outside.
   task automatic load_cube(input int half);
      csr_write(PLANE_LEFT,   plane_word( Q_ONE, 0, 0, half));
      csr_write(PLANE_RIGHT,  plane_word(-Q_ONE, 0, 0, half));
      csr_write(PLANE_BOTTOM, plane_word(0,  Q_ONE, 0, half));
      csr_write(PLANE_TOP,    plane_word(0, -Q_ONE, 0, half));
      csr_write(PLANE_FAR,    plane_word(0, 0, -Q_ONE, half));
      csr_write(PLANE_NEAR,   plane_word(0, 0,  Q_ONE, half));
      check_plane_readback();
   endtask

   function automatic cull_item_type make_item(input mode_type m,
                                               input int lx, input int ly, input int lz,
                                               input int hx, input int hy, input int hz);
      cull_item_type item;
      item.mode = m;
      item.lo_x = CW'(lx);
      item.lo_y = CW'(ly);
      item.lo_z = CW'(lz);
      item.hi_x = CW'(hx);
      item.hi_y = CW'(hy);
      item.hi_z = CW'(hz);
      return item;
   endfunction

   // Zero span means the full coordinate range.
   function automatic logic signed [CW-1:0] pick_coord(input int span);
      if (span == 0)
         return CW'($urandom);
      return CW'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   // Mostly ordered boxes near the planes of interest; a quarter use the
   // full range, and an eighth keep lo and hi as drawn, swapped or not.
   function automatic cull_item_type make_random_item(input int span);
      cull_item_type          item;
      int                     use_span;
      logic signed [CW-1:0]   u [6];
      logic signed [CW-1:0]   t;
      bit                     keep_order;
      use_span   = ($urandom_range(0, 3) == 0) ? 0 : span;
      keep_order = ($urandom_range(0, 7) != 0);
      for (int i = 0; i < 6; i++)
         u[i] = pick_coord(use_span);
      for (int i = 0; i < 3; i++) begin
         if (keep_order && u[i] > u[i + 3]) begin
            t        = u[i];
            u[i]     = u[i + 3];
            u[i + 3] = t;
         end
      end
      item.mode = $urandom_range(0, 1) ? MODE_POINT : MODE_BOX;
      item.lo_x = u[0];
      item.lo_y = u[1];
      item.lo_z = u[2];
      item.hi_x = u[3];
      item.hi_y = u[4];
      item.hi_z = u[5];
      return item;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Planes are all zero after reset: every box and point is rejected.
   task automatic test_zero_planes;
      send_item(make_item(MODE_BOX, COORD_MIN, COORD_MIN, COORD_MIN,
                          COORD_MAX, COORD_MAX, COORD_MAX));
      send_item(make_item(MODE_POINT, 0, 0, 0, 0, 0, 0));
      send_item(make_item(MODE_BOX, 1, 1, 1, 1, 1, 1));
      send_item(make_item(MODE_POINT, COORD_MAX, COORD_MIN, COORD_MAX, 0, 0, 0));
      wait_drained();
      check_plane_readback();
   endtask

   // Cube of half size 1000: inside, straddling, outside, on a face,
   // swapped bounds and ignored hi fields in point mode.
   task automatic test_cube_cases;
      load_cube(1000);
      send_item(make_item(MODE_BOX,   -10, -10, -10, 10, 10, 10));
      send_item(make_item(MODE_POINT, 0, 0, 0, 0, 0, 0));
      send_item(make_item(MODE_POINT, -1000, 0, 0, 0, 0, 0));   // on the left face
      send_item(make_item(MODE_POINT, -999, 0, 0, 0, 0, 0));
      send_item(make_item(MODE_BOX,   -1500, -10, -10, -500, 10, 10));
      send_item(make_item(MODE_BOX,   -3000, -10, -10, -1001, 10, 10));
      send_item(make_item(MODE_BOX,   -3000, -10, -10, -1000, 10, 10)); // touches face
      send_item(make_item(MODE_BOX,   COORD_MIN, COORD_MIN, COORD_MIN,
                                      COORD_MAX, COORD_MAX, COORD_MAX));
      send_item(make_item(MODE_BOX,   500, 500, 500, -500, -500, -500)); // swapped
      send_item(make_item(MODE_BOX,   -1001, 0, 0, -3000, 5, 5));        // swapped, out
      send_item(make_item(MODE_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0));
      send_item(make_item(MODE_POINT, 0, 0, 0, COORD_MIN, COORD_MAX, COORD_MIN));
      send_item(make_item(MODE_BOX,   COORD_MIN, COORD_MIN, COORD_MIN,
                                      COORD_MIN, COORD_MIN, COORD_MIN));
      wait_drained();
   endtask

   // Extreme coefficients on every plane; writes past the last plane
   // must leave everything unchanged.
   task automatic test_extreme_planes;
      for (int p = 0; p < PLANE_COUNT; p++)
         csr_write(p, p[0] ? plane_word(32767, 32767, 32767, -32768)
                           : plane_word(-32768, -32768, -32768, 32767));
      csr_write(PLANE_COUNT,     '1);
      csr_write(PLANE_COUNT + 1, '1);
      check_plane_readback();
      send_item(make_item(MODE_POINT, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0));
      send_item(make_item(MODE_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0));
      send_item(make_item(MODE_POINT, 0, 0, 0, 0, 0, 0));
      send_item(make_item(MODE_BOX,   COORD_MIN, COORD_MIN, COORD_MIN,
                                      COORD_MAX, COORD_MAX, COORD_MAX));
      send_item(make_item(MODE_BOX,   COORD_MAX, COORD_MAX, COORD_MAX,
                                      COORD_MAX, COORD_MAX, COORD_MAX));
      wait_drained();
   endtask

   // Hold the output off while requests keep coming, so the pipeline
   // fills and backs up into the request channel.
   task automatic test_stall_backlog;
      load_cube(2000);
      hold_off_request = 1'b1;
      for (int i = 0; i < 20; i++)
         send_item(make_random_item(3000));
      wait_drained();
   endtask

   // Random transactions over several plane sets; idling on both sides
   // except in the last phase.
   task automatic test_random_traffic;
      int half;
      int span;
      for (int phase = 0; phase < 6; phase++) begin
         half = $urandom_range(100, 20000);
         span = (half * 2 > 32767) ? 32767 : half * 2;
         unique case (phase % 3)
            0: begin
               load_cube(half);
            end
            1: begin
               // Tilted planes with the origin on or in front of each.
               for (int p = 0; p < PLANE_COUNT; p++)
                  csr_write(p, plane_word(int'($urandom_range(0, 32767)) - 16384,
                                          int'($urandom_range(0, 32767)) - 16384,
                                          int'($urandom_range(0, 32767)) - 16384,
                                          $urandom_range(0, half)));
               check_plane_readback();
            end
            default: begin
               for (int p = 0; p < PLANE_COUNT; p++)
                  csr_write(p, {$urandom, $urandom});
               check_plane_readback();
            end
         endcase
         sender_gaps   = (phase != 5);
         receiver_gaps = (phase != 5);
         for (int i = 0; i < 115; i++)
            send_item(make_random_item(span));
         wait_drained();
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zero_planes();
      test_cube_cases();
      test_extreme_planes();
      test_stall_backlog();
      test_random_traffic();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Safety net far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
